/* rtl/core/bounded_sequential_list_defines.svh */
// Assertion macros shared by the checker of the bounded sequential list.
`ifndef BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_sequential_list: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_sequential_list: next-cycle check failed");

`endif

/* rtl/core/bsl_pkg.sv */
// Package with the widths, codes and shared types of the bounded sequential list.
`default_nettype none
package bsl_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int FOUND_W  = 8;
  localparam int COUNT_W  = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_APPEND = 3'd4,
    OP_POP    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIN
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              load;
    logic              shift_up;
    logic              shift_dn;
    logic [CMP_W-1:0]  tgt;
    logic [CMP_W-1:0]  used;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/bsl_in_if.sv */
// Request channel interface of the bounded sequential list.
`default_nettype none
interface bsl_in_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      op;
  logic [6:0]                      position;
  logic signed [31:0]              value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface
`default_nettype wire

/* rtl/core/bsl_out_if.sv */
// Result channel interface of the bounded sequential list.
`default_nettype none
interface bsl_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] read_value;
  logic signed [7:0]  found_index;
  logic [7:0]         count;
  logic               is_empty;

  modport source (output valid, output ok, output read_value, output found_index,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input ok, input read_value, input found_index,
                  input count, input is_empty, output ready);
endinterface
`default_nettype wire

/* rtl/core/bsl_cell.sv */
// One storage cell of the list chain: holds one entry, shifts, loads and compares.
`default_nettype none
module bsl_cell (
  input  logic                        clk,
  input  logic [bsl_pkg::CMP_W-1:0]   idx_i,
  input  bsl_pkg::cell_ctl_t          ctl_i,
  input  logic [bsl_pkg::DATA_W-1:0]  left_i,
  input  logic [bsl_pkg::DATA_W-1:0]  right_i,
  output logic [bsl_pkg::DATA_W-1:0]  entry_o,
  output logic                        hit_o,
  output logic [bsl_pkg::DATA_W-1:0]  rd_o
);
  import bsl_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.shift_up && (idx_i > ctl_i.tgt)) begin
      entry_nxt = left_i;
    end else if (ctl_i.shift_dn && (idx_i >= ctl_i.tgt)) begin
      entry_nxt = right_i;
    end else if (ctl_i.load && (idx_i == ctl_i.tgt)) begin
      entry_nxt = ctl_i.data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign hit_o   = (idx_i < ctl_i.used) && (entry_r == ctl_i.data);
  assign rd_o    = (idx_i == ctl_i.tgt) ? entry_r : '0;
endmodule
`default_nettype wire

/* rtl/core/bsl_pick.sv */
// Priority encoder that finds the lowest cell reporting a match.
`default_nettype none
module bsl_pick (
  input  logic [bsl_pkg::CAPACITY-1:0] hits_i,
  output logic                         any_o,
  output logic [bsl_pkg::FOUND_W-1:0]  first_o
);
  import bsl_pkg::*;

  always_comb begin
    first_o = '1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits_i[i]) begin
        first_o = FOUND_W'(i);
      end
    end
  end

  assign any_o = |hits_i;
endmodule
`default_nettype wire

/* rtl/core/bounded_sequential_list.sv */
// Top level of the bounded sequential list: a chain of value cells with a request sequencer.
//
//   Channel | Role   | Beat carries
//   in_ch   | sink   | op, position, value
//   out_ch  | source | ok, read_value, found_index, count, is_empty
//
// Every request beat yields exactly one result beat. A request is taken, the cell chain
// works on it in the next cycle (compare, gather and shift all in parallel), and the
// finishing step then encodes the match and loads the result register; in the cycle in
// which it loads, the next request may already be taken.
// Reset is synchronous and active low; it empties the list but leaves the cell contents as
// they are, since only entries below the fill count are ever read.
// While the result register holds a beat not yet taken, the finishing step waits, and while
// it waits no new request is taken.
`default_nettype none
module bounded_sequential_list (
  input  logic       clk,
  input  logic       rst_n,
  bsl_in_if.sink     in_ch,
  bsl_out_if.source  out_ch
);
  import bsl_pkg::*;

  // Sequencer state and the request held while the chain works on it.
  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   val_r;
  logic [CNT_W-1:0]    used_r, used_nxt;

  // Values gathered from the chain in the working cycle.
  logic [CAPACITY-1:0] hits_r;
  logic [DATA_W-1:0]   rd_r;
  logic                ok_r, ok_nxt;

  // Result register.
  logic                out_valid_r;
  logic                out_ok_r;
  logic [DATA_W-1:0]   out_rd_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_empty_r;

  logic                in_ready;
  logic                in_accept;
  logic                out_load;
  logic                do_eval;
  cell_ctl_t           ctl;

  logic [DATA_W-1:0]   entry  [CAPACITY];
  logic [DATA_W-1:0]   rd_w   [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [DATA_W-1:0]   rd_any;
  logic                pick_any;
  logic [FOUND_W-1:0]  pick_first;

  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    used_c;
  logic                pos_lt;
  logic                not_full;
  logic                not_empty;

  assign pos_c     = CMP_W'(pos_r);
  assign used_c    = CMP_W'(used_r);
  assign pos_lt    = pos_c < used_c;
  assign not_full  = used_r < CNT_W'(CAPACITY);
  assign not_empty = used_r != '0;

  // Success of the request and the resulting fill count; a failed request changes nothing.
  always_comb begin
    ok_nxt   = 1'b0;
    used_nxt = used_r;
    case (op_r)
      OP_GET: begin
        ok_nxt = pos_lt;
      end
      OP_LOCATE: begin
        ok_nxt = 1'b0;
      end
      OP_INSERT: begin
        ok_nxt = not_full && pos_lt;
        if (ok_nxt) begin
          used_nxt = used_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        ok_nxt = pos_lt;
        if (ok_nxt) begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
      OP_APPEND: begin
        ok_nxt = not_full;
        if (ok_nxt) begin
          used_nxt = used_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        ok_nxt = not_empty;
        if (ok_nxt) begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Command to the chain. Shifts and loads are only enabled in the working cycle; the key,
  // target and fill count are always driven so that the compare outputs settle.
  always_comb begin
    ctl.load     = do_eval && ok_nxt && ((op_r == OP_INSERT) || (op_r == OP_APPEND));
    ctl.shift_up = do_eval && ok_nxt && (op_r == OP_INSERT);
    ctl.shift_dn = do_eval && ok_nxt && (op_r == OP_DELETE);
    ctl.tgt      = (op_r == OP_APPEND) ? used_c : pos_c;
    ctl.used     = used_c;
    ctl.data     = val_r;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = entry[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = entry[g+1];
      end
      bsl_cell u_cell (
        .clk     (clk),
        .idx_i   (CMP_W'(g)),
        .ctl_i   (ctl),
        .left_i  (left_w),
        .right_i (right_w),
        .entry_o (entry[g]),
        .hit_o   (hits[g]),
        .rd_o    (rd_w[g])
      );
    end
  endgenerate

  // At most one cell drives a non-zero read word, so an OR gathers the selected entry.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  bsl_pick u_pick (
    .hits_i  (hits_r),
    .any_o   (pick_any),
    .first_o (pick_first)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = in_accept ? ST_EVAL : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
    do_eval   = (state_r == ST_EVAL);
    in_ready  = (state_r == ST_IDLE) || out_load;
    in_accept = in_ch.valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_eval) begin
        used_r <= used_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= op_t'(in_ch.op);
      pos_r <= in_ch.position;
      val_r <= in_ch.value;
    end
    if (do_eval) begin
      hits_r <= hits;
      rd_r   <= rd_any;
      ok_r   <= ok_nxt;
    end
    if (out_load) begin
      out_ok_r    <= (op_r == OP_LOCATE) ? pick_any : ok_r;
      out_rd_r    <= (op_r == OP_GET) ? (ok_r ? rd_r : '1) : '0;
      out_found_r <= ((op_r == OP_LOCATE) && pick_any) ? pick_first : '1;
      out_count_r <= COUNT_W'(used_r);
      out_empty_r <= (used_r == '0);
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
endmodule
`default_nettype wire

/* rtl/core/bsl_checker.sv */
// Port-level checks on the bounded sequential list and the bind that attaches them.
`default_nettype none
`include "bounded_sequential_list_defines.svh"
module bsl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic signed [31:0] out_read_value,
  input logic signed [7:0] out_found_index,
  input logic [7:0]        out_count,
  input logic              out_is_empty
);
  // A request beat keeps the block busy for at least the following cycle.
  `BSL_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // A found position is only reported together with success.
  `BSL_ASSERT_SAME(a_found_implies_ok, out_valid && (out_found_index != 8'shFF), out_ok)
  // A found position excludes a read word, which belongs to get only.
  `BSL_ASSERT_SAME(a_found_no_read, out_valid && (out_found_index != 8'shFF),
                   out_read_value == 32'sd0)
  // A stalled result beat is held unchanged.
  `BSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_ok) && $stable(out_read_value) &&
                   $stable(out_found_index) && $stable(out_count) && $stable(out_is_empty))
endmodule

bind bounded_sequential_list bsl_checker u_bsl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_read_value  (out_ch.read_value),
  .out_found_index (out_ch.found_index),
  .out_count       (out_ch.count),
  .out_is_empty    (out_ch.is_empty)
);
`default_nettype wire

/* dv/bounded_sequential_list_checker.sv */
// Checker for the bounded sequential list: predicts every result beat and compares it.
module bounded_sequential_list_checker
  import bsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bsl_in_if           in_ch,
  bsl_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned beats_checked,
  output int unsigned locate_hits,
  output int unsigned capacity_hits
);

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  read_value;
    logic signed [FOUND_W-1:0] found_index;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } list_result_t;

  // Shadow copy of the list contents and fill level.
  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int                shadow_used;

  list_result_t      expected_results [$];
  int unsigned       fail_tally;
  int unsigned       checked_tally;
  int unsigned       hit_tally;
  int unsigned       full_tally;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t list_apply_request(input logic [OP_W-1:0]   op,
                                                      input logic [POS_W-1:0]  pos,
                                                      input logic [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    int           i;
    r.ok          = 1'b0;
    r.read_value  = '0;
    r.found_index = '1;
    p             = int'(pos);
    case (op)
      OP_GET: begin
        if (p < shadow_used) begin
          r.read_value = shadow_entries[p];
          r.ok         = 1'b1;
        end else begin
          r.read_value = '1;
        end
      end
      OP_LOCATE: begin
        for (i = 0; i < shadow_used && !r.ok; i++) begin
          if (shadow_entries[i] == val) begin
            r.found_index = FOUND_W'(i);
            r.ok          = 1'b1;
          end
        end
      end
      OP_INSERT: begin
        if (shadow_used < CAPACITY && p < shadow_used) begin
          for (i = shadow_used; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = val;
          shadow_used++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p < shadow_used) begin
          for (i = p; i + 1 < shadow_used; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_used--;
          r.ok = 1'b1;
        end
      end
      OP_APPEND: begin
        if (shadow_used < CAPACITY) begin
          shadow_entries[shadow_used] = val;
          shadow_used++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_used != 0) begin
          shadow_used--;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count    = COUNT_W'(shadow_used);
    r.is_empty = (shadow_used == 0);
    return r;
  endfunction

  task automatic note_mismatch(input string fname, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
    fail_tally++;
    $display("%0t: %s mismatch on result beat %0d: expected %0d, actual %0d",
             $time, fname, checked_tally, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      shadow_used = 0;
      expected_results.delete();
      fail_tally    = 0;
      checked_tally = 0;
      hit_tally     = 0;
      full_tally    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = list_apply_request(in_ch.op, in_ch.position, in_ch.value);
        expected_results.push_back(want);
        if (in_ch.op == OP_LOCATE && want.ok) hit_tally++;
        if ((in_ch.op == OP_APPEND || in_ch.op == OP_INSERT) && want.ok &&
            shadow_used == CAPACITY) full_tally++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.ok          = out_ch.ok;
        got.read_value  = out_ch.read_value;
        got.found_index = out_ch.found_index;
        got.count       = out_ch.count;
        got.is_empty    = out_ch.is_empty;
        if (expected_results.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected result beat: expected none, actual ok=%0b read_value=%0d",
                   $time, got.ok, got.read_value);
          $display("%0t:   found_index=%0d count=%0d is_empty=%0b",
                   $time, got.found_index, got.count, got.is_empty);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok) note_mismatch("ok", want.ok, got.ok);
          if (got.read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, got.read_value);
          if (got.found_index !== want.found_index)
            note_mismatch("found_index", want.found_index, got.found_index);
          if (got.count !== want.count) note_mismatch("count", want.count, got.count);
          if (got.is_empty !== want.is_empty)
            note_mismatch("is_empty", want.is_empty, got.is_empty);
        end
        checked_tally++;
      end
    end
    mismatches    <= fail_tally;
    awaited       <= expected_results.size();
    beats_checked <= checked_tally;
    locate_hits   <= hit_tally;
    capacity_hits <= full_tally;
  end

endmodule

/* dv/bounded_sequential_list_tb.sv */
// Testbench top of the bounded sequential list: clock, reset, request and result traffic, verdict.
module bounded_sequential_list_tb;
  import bsl_pkg::*;

  // Generous ceiling on the whole run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Number of appends (or pops) that certainly fills (or drains) the list in one round.
  localparam int          SWEEP_OPS   = CAPACITY + 12;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count;
  int unsigned requests_sent;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned beats_checked;
  int unsigned locate_hits;
  int unsigned capacity_hits;

  bsl_in_if  in_ch ();
  bsl_out_if out_ch ();

  bounded_sequential_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker sits beside the block, watches both channels and keeps the score.
  bounded_sequential_list_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .beats_checked (beats_checked),
    .locate_hits   (locate_hits),
    .capacity_hits (capacity_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: should the block hang, the run ends here rather than running on for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side. Ready is redrawn every cycle, so that a stall may land on any beat,
  // including the one that the block has only just loaded into its result register.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drives one request beat and returns at the clock edge at which it is taken. Any idle
  // cycles come first, so valid is only ever lowered in a step of its own. Ready is read
  // straight after the edge, before the block's own updates of that step have landed.
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [POS_W-1:0]  pos,
                              input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Values come from a small pool often enough that locate finds matches and duplicates,
  // with the extremes and fully random words mixed in so that every bit toggles.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5:       return '1;
      6:       return '0;
      default: return $urandom_range(7) - 32'd3;
    endcase
  endfunction

  // Positions lean towards the low end, where the list usually has entries, but the
  // top of the range is drawn too, for both valid and out-of-range accesses.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(3))
      0:       return POS_W'($urandom_range(3));
      1:       return POS_W'($urandom_range(31));
      2:       return POS_W'($urandom_range(127));
      default: return POS_W'($urandom_range(127, 96));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_lookup_op();
    return ($urandom_range(1) == 0) ? OP_GET : OP_LOCATE;
  endfunction

  // Hand-picked opening: the empty list, the value extremes, every operation and the
  // failing cases of each but append, including the two unused opcodes.
  task automatic run_directed();
    send_request(OP_POP,    7'd0,   32'd0);          // nothing to pop
    send_request(OP_GET,    7'd0,   32'd0);          // read from an empty list
    send_request(OP_DELETE, 7'd0,   32'd0);          // delete from an empty list
    send_request(OP_INSERT, 7'd0,   32'd9);          // insert needs an existing position
    send_request(OP_LOCATE, 7'd0,   32'd0);          // search of an empty list
    send_request(OP_APPEND, 7'd0,   32'h8000_0000);
    send_request(OP_APPEND, 7'd127, 32'h7fff_ffff);
    send_request(OP_APPEND, 7'd0,   32'hffff_ffff);
    send_request(OP_APPEND, 7'd0,   32'h0000_0000);
    send_request(OP_GET,    7'd0,   32'd0);
    send_request(OP_GET,    7'd3,   32'd0);          // last entry in use
    send_request(OP_GET,    7'd4,   32'd0);          // one past the end
    send_request(OP_GET,    7'd127, 32'd0);
    send_request(OP_LOCATE, 7'd0,   32'h7fff_ffff);
    send_request(OP_LOCATE, 7'd0,   32'h1234_5678);  // no match
    send_request(OP_INSERT, 7'd0,   32'h5a5a_5a5a);  // at the head
    send_request(OP_INSERT, 7'd4,   32'h0000_0001);  // at the last occupied slot
    send_request(OP_DELETE, 7'd0,   32'd0);
    send_request(OP_DELETE, 7'd4,   32'd0);          // the tail
    send_request(OP_DELETE, 7'd127, 32'd0);          // out of range
    send_request(3'd6,      7'd5,   32'hdead_beef);
    send_request(3'd7,      7'd127, 32'hffff_ffff);
    send_request(OP_POP,    7'd0,   32'd0);
    send_request(OP_LOCATE, 7'd0,   32'hffff_ffff);
    send_request(OP_GET,    7'd1,   32'd0);
  endtask

  // One round takes the list from whatever it holds up to capacity, exercises the full
  // list, wanders at random for a while and then drains it back to empty.
  task automatic run_random_round();
    int ops_done;
    int n;

    ops_done = 0;
    while (ops_done < SWEEP_OPS) begin
      case ($urandom_range(9))
        0, 1:    send_request(OP_INSERT, pick_position(), pick_value());
        2:       send_request(pick_lookup_op(), pick_position(), pick_value());
        default: begin
          send_request(OP_APPEND, pick_position(), pick_value());
          ops_done++;
        end
      endcase
    end

    // The list is now full: growth must be refused, the top slot must be reachable.
    send_request(OP_APPEND, pick_position(), pick_value());
    send_request(OP_INSERT, 7'd0, pick_value());
    send_request(OP_INSERT, 7'd127, pick_value());
    send_request(OP_GET, 7'd127, 32'd0);
    send_request(OP_LOCATE, pick_position(), pick_value());
    send_request(OP_DELETE, 7'd127, 32'd0);
    send_request(OP_APPEND, pick_position(), pick_value());
    send_request(OP_GET, 7'd0, 32'd0);

    // Free mix, unused opcodes included as noise.
    for (n = 0; n < 60; n++) begin
      send_request(OP_W'($urandom_range(7)), pick_position(), pick_value());
    end

    ops_done = 0;
    while (ops_done < SWEEP_OPS) begin
      case ($urandom_range(9))
        0, 1:    send_request(OP_DELETE, pick_position(), pick_value());
        2:       send_request(pick_lookup_op(), pick_position(), pick_value());
        default: begin
          send_request(OP_POP, pick_position(), pick_value());
          ops_done++;
        end
      endcase
    end

    // Empty again: every operation that needs an entry must fail.
    send_request(OP_POP, pick_position(), pick_value());
    send_request(OP_GET, 7'd0, 32'd0);
    send_request(OP_DELETE, 7'd0, 32'd0);
    send_request(OP_INSERT, 7'd0, pick_value());
    send_request(OP_LOCATE, pick_position(), pick_value());
  endtask

  initial begin : stimulus
    int unsigned round;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_GET;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    requests_sent  = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Four handshake regimes: free flowing, a lazy sender, a slow receiver, and both.
    for (round = 0; round < 4; round++) begin
      case (round)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 45; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 45; end
        default: begin send_gap_pct = 20; recv_stall_pct = 20; end
      endcase
      run_random_round();
    end

    // Let the last beat reach the checker, then wait for every result to come back.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results under four handshake regimes;",
             requests_sent, beats_checked);
    $display("locate matched %0d times and the list was filled to capacity %0d times.",
             locate_hits, capacity_hits);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
